/* rtl/core/ffve_pkg.sv */
// ----------------------------------------------------------------------------
// ffve_pkg
// Shared types, codes and helpers for the form field value extractor.
// ----------------------------------------------------------------------------
package ffve_pkg;

  localparam int KEY_BYTES_DEF    = 8;
  localparam int CAPACITY_MAX_DEF = 4096;

  localparam int BYTE_W      = 8;
  localparam int KEY_REG_W   = 64;
  localparam int KEY_LEN_W   = 4;
  localparam int CAP_W       = 13;
  localparam int VALUE_LEN_W = 12;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CAPACITY = 2'd2;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd4096;

  // Characters with a special meaning in a form body.
  localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_PERCENT = 8'h25;
  localparam logic [BYTE_W-1:0] CH_AMP     = 8'h26;
  localparam logic [BYTE_W-1:0] CH_EQUALS  = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

  typedef enum logic [2:0] {
    PH_MATCH,
    PH_SKIP,
    PH_VALUE,
    PH_HEX1,
    PH_HEX2,
    PH_ENDED,
    PH_BAD,
    PH_NOSPACE
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND,
    ST_NOTFOUND,
    ST_BADESC,
    ST_NOSPACE
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] body_byte;
    logic              body_last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      value_byte;
    logic                   byte_valid;
    logic                   done_res;
    status_t                status;
    logic [VALUE_LEN_W-1:0] value_length;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  // Decodes one ASCII hex digit of either case.
  function automatic hex_t hex_digit(input logic [BYTE_W-1:0] c);
    hex_t r;
    r.ok     = 1'b1;
    r.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.nibble = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

/* rtl/core/form_field_value_extractor_unit.sv */
// ----------------------------------------------------------------------------
// form_field_value_extractor_unit
// Finds one field of a URL-form-encoded body and streams its decoded value.
// ----------------------------------------------------------------------------
// The body arrives one byte per transfer on the input channel, with body_last
// on its final byte. The unit looks for the first field whose name equals the
// configured key and is followed by '=', then emits that field's value one
// decoded byte per result transfer ('+' becomes a space, %XX becomes one byte).
// The final byte of every body produces a result with done_res set and a
// status: found, not found, bad escape, or no space. On an error status the
// bytes already delivered for that body must be dropped by the receiver.
// Each input byte is handled by the parser state and lands in a two-entry
// output buffer, so the unit takes one byte per clock as long as results drain;
// the input side stalls only when both buffer entries hold results not yet
// taken downstream. Configuration registers are written through the plain
// write port while the body stream is idle, which the unit leaves to the user.
module form_field_value_extractor_unit
  import ffve_pkg::*;
#(
  parameter int KEY_BYTES    = KEY_BYTES_DEF,
  parameter int CAPACITY_MAX = CAPACITY_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The capacity register is 13 bits wide, so a limit above its range never
  // clamps anything; the count only ever needs to reach capacity minus one.
  localparam int CAP_EFF = (CAPACITY_MAX < 8191) ? CAPACITY_MAX : 8191;
  localparam int CNT_W   = $clog2(CAP_EFF);
  localparam int KPOS_W  = $clog2(KEY_BYTES + 1);
  localparam int KIDX_W  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int KEY_W   = 8 * KEY_BYTES;
  localparam logic [CAP_W-1:0]     CAP_LIM = CAP_W'(CAP_EFF);
  localparam logic [KEY_LEN_W-1:0] KLEN_MAX = KEY_LEN_W'(KEY_BYTES);

  // Configuration registers.
  logic [KEY_W-1:0]     key_reg;
  logic [KEY_LEN_W-1:0] key_length;
  logic [CAP_W-1:0]     value_capacity;

  // Parser state.
  phase_t            phase, phase_next;
  logic [KPOS_W-1:0] key_position, key_position_next;
  logic [3:0]        high_nibble, high_nibble_next;
  logic [CNT_W-1:0]  emitted_count, emitted_count_next;

  // Output buffer: the head register drives the port, the skid entry holds
  // a second result while the head waits.
  out_item_t skid_data;
  logic      skid_valid;

  logic              accept;
  logic              have;
  logic [BYTE_W-1:0] ch;
  out_item_t         result;
  logic              push, pop;

  logic [KEY_LEN_W-1:0] klen;
  logic [CAP_W-1:0]     cap;
  logic                 room;
  logic                 key_done;
  logic [KIDX_W-1:0]    key_idx;
  logic [BYTE_W-1:0]    key_char;
  hex_t                 hex;
  logic [BYTE_W-1:0]    b;

  assign accept = in_valid && in_ready;
  assign b      = in_data.body_byte;

  assign klen     = (key_length > KLEN_MAX) ? KLEN_MAX : key_length;
  assign cap      = (value_capacity > CAP_LIM) ? CAP_LIM : value_capacity;
  // One more character fits when the count after it stays below capacity.
  assign room     = ({1'b0, CAP_W'(emitted_count)} + 14'd1) < {1'b0, cap};
  assign key_done = KEY_LEN_W'(key_position) >= klen;
  assign key_idx  = KIDX_W'(key_position);
  assign key_char = key_reg[8 * key_idx +: 8];
  assign hex      = hex_digit(b);

  // Next-state logic of the parser.
  always_comb begin
    phase_next         = phase;
    key_position_next  = key_position;
    high_nibble_next   = high_nibble;
    emitted_count_next = emitted_count;
    have               = 1'b0;
    ch                 = '0;
    unique case (phase)
      PH_MATCH: begin
        if (b == CH_AMP) begin
          key_position_next = '0;
        end else if (key_done) begin
          phase_next = (b == CH_EQUALS) ? PH_VALUE : PH_SKIP;
        end else if (b == CH_EQUALS) begin
          phase_next = PH_SKIP;
        end else if (b == key_char) begin
          key_position_next = key_position + KPOS_W'(1);
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == CH_AMP) begin
          phase_next        = PH_MATCH;
          key_position_next = '0;
        end
      end
      PH_VALUE: begin
        if (b == CH_AMP) begin
          phase_next = PH_ENDED;
        end else if (b == CH_PERCENT) begin
          phase_next = PH_HEX1;
        end else if (room) begin
          have               = 1'b1;
          ch                 = (b == CH_PLUS) ? CH_SPACE : b;
          emitted_count_next = emitted_count + CNT_W'(1);
        end else begin
          phase_next = PH_NOSPACE;
        end
      end
      PH_HEX1: begin
        if (!hex.ok) begin
          phase_next = PH_BAD;
        end else begin
          high_nibble_next = hex.nibble;
          phase_next       = PH_HEX2;
        end
      end
      PH_HEX2: begin
        if (!hex.ok) begin
          phase_next = PH_BAD;
        end else if (room) begin
          have               = 1'b1;
          ch                 = {high_nibble, hex.nibble};
          phase_next         = PH_VALUE;
          emitted_count_next = emitted_count + CNT_W'(1);
        end else begin
          phase_next = PH_NOSPACE;
        end
      end
      PH_ENDED, PH_BAD, PH_NOSPACE: begin
      end
      default: begin
      end
    endcase
  end

  // Result of the current byte; the status follows the phase after it.
  always_comb begin
    result.value_byte   = ch;
    result.byte_valid   = have;
    result.done_res     = in_data.body_last;
    result.status       = ST_FOUND;
    result.value_length = VALUE_LEN_W'(emitted_count_next);
    if (in_data.body_last) begin
      unique case (phase_next)
        PH_MATCH, PH_SKIP:          result.status = ST_NOTFOUND;
        PH_HEX1, PH_HEX2, PH_BAD:   result.status = ST_BADESC;
        PH_NOSPACE:                 result.status = ST_NOSPACE;
        default:                    result.status = ST_FOUND;
      endcase
    end
  end

  // Parser registers; every last byte brings the parser back to field start.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_MATCH;
      key_position  <= '0;
      high_nibble   <= '0;
      emitted_count <= '0;
    end else if (accept) begin
      if (in_data.body_last) begin
        phase         <= PH_MATCH;
        key_position  <= '0;
        high_nibble   <= '0;
        emitted_count <= '0;
      end else begin
        phase         <= phase_next;
        key_position  <= key_position_next;
        high_nibble   <= high_nibble_next;
        emitted_count <= emitted_count_next;
      end
    end
  end

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg        <= '0;
      key_length     <= '0;
      value_capacity <= CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY_BYTES:      key_reg        <= cfg_data[KEY_W-1:0];
        CFG_KEY_LENGTH:     key_length     <= cfg_data[KEY_LEN_W-1:0];
        CFG_VALUE_CAPACITY: value_capacity <= cfg_data[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A byte makes a result when it decodes a character or ends the body.
  assign push     = accept && (have || in_data.body_last);
  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end
  end

  // The skid entry is only ever filled behind a waiting head result.
  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while the head is empty");

  // A body's final byte returns the parser to the start of a field.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.body_last |=> phase == PH_MATCH && emitted_count == '0)
    else $error("parser state not cleared after the last byte");

  // Only a final result carries a status other than found.
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.done_res |-> out_data.status == ST_FOUND)
    else $error("status set on a result that does not end the body");

  // A push with the head stalled and the skid free must land in the skid entry.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    push && out_valid && !out_ready |=> skid_valid)
    else $error("result lost while the head was stalled");

endmodule
